// File: rtl/csvrt_pkg.sv
// ----------------------------------------------------------------------------
// csvrt_pkg
// Shared types and constants of the CSV record tokenizer: transaction
// payloads, result kinds, error codes, scan modes and character codes.
// ----------------------------------------------------------------------------
package csvrt_pkg;

	localparam int FIELD_BUFFER_LEN_DEF = 128;
	localparam int ROW_COUNT_BITS_DEF   = 24;

	localparam int ROWS_W    = 24;
	localparam int ACCOUNT_W = 30;

	localparam int ID_MAX_LEN   = 9;
	localparam int IBAN_MAX_LEN = 34;
	localparam int REF_MAX_LEN  = 100;
	localparam int LAST_FIELD   = 3;
	localparam int FIELD_SAT    = 4;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		K_CHAR      = 3'd0,
		K_FIELD_END = 3'd1,
		K_ROW_END   = 3'd2,
		K_ERROR     = 3'd3,
		K_DONE      = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		E_NONE         = 4'd0,
		E_QUOTE_UNQ    = 4'd1,
		E_AFTER_QUOTE  = 4'd2,
		E_NO_END_QUOTE = 4'd3,
		E_FIELD_LONG   = 4'd4,
		E_ID_LONG      = 4'd5,
		E_ID_NONNUM    = 4'd6,
		E_IBAN_LONG    = 4'd7,
		E_REF_LONG     = 4'd8,
		E_VALUE_COUNT  = 4'd9,
		E_NO_ROWS      = 4'd10
	} err_t;

	typedef enum logic [5:0] {
		M_START  = 6'b000001,
		M_PLAIN  = 6'b000010,
		M_QUOTED = 6'b000100,
		M_QSEEN  = 6'b001000,
		M_CRSEEN = 6'b010000,
		M_ENDED  = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       carries_byte;
		logic       final_req;
	} in_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           field_char;
		logic [2:0]           field_number;
		logic [ACCOUNT_W-1:0] account_value;
		logic [ROWS_W-1:0]    rows_done;
		err_t                 error_code;
		logic                 last_of_run;
	} out_t;

	// Results caused by one input transaction, in order.
	typedef struct packed {
		logic [1:0]     cnt;
		out_t [2:0]     r;
	} bnd_t;

	typedef struct packed {
		logic load;
		bnd_t bundle;
	} load_t;

endpackage

// File: rtl/csvrt_core.sv
// ----------------------------------------------------------------------------
// csvrt_core
// Scanner state and the single-pass decode of one registered input
// transaction into up to three results and the next scanner state.
// ----------------------------------------------------------------------------
module csvrt_core import csvrt_pkg::*; #(
	parameter int FIELD_BUFFER_LEN = FIELD_BUFFER_LEN_DEF,
	parameter int ROW_COUNT_BITS   = ROW_COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  in_t  item_s1,
	output bnd_t bundle
);

	localparam int CNT_W = $clog2(FIELD_BUFFER_LEN);
	localparam int ROW_W = ROW_COUNT_BITS;

	typedef struct packed {
		mode_t                mode;
		logic [2:0]           pos;
		logic [CNT_W-1:0]     cnt;
		logic [ACCOUNT_W-1:0] acc;
		logic                 dbad;
		logic [ROW_W-1:0]     rows;
	} st_t;

	typedef struct packed {
		st_t  st;
		logic vld;
		out_t res;
	} step_t;

	typedef struct packed {
		st_t        st;
		logic [1:0] n;
		out_t       r0;
		out_t       r1;
	} fin_t;

	st_t   st_q;
	step_t byte_step;
	fin_t  fin_step;
	st_t   nxt;

	function automatic out_t mk(input st_t s, input kind_t k, input logic [7:0] ch,
			input err_t e);
		out_t        r;
		logic [31:0] rw;
		rw = 32'(s.rows);
		r.kind          = k;
		r.field_char    = ch;
		r.field_number  = s.pos;
		r.account_value = s.acc;
		r.rows_done     = rw[ROWS_W-1:0];
		r.error_code    = e;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	function automatic step_t none(input st_t s);
		step_t o;
		o.st  = s;
		o.vld = 1'b0;
		o.res = mk(s, K_CHAR, 8'h00, E_NONE);
		return o;
	endfunction

	function automatic step_t fail(input st_t s, input err_t e);
		step_t o;
		o.st      = s;
		o.st.mode = M_ENDED;
		o.vld     = 1'b1;
		o.res     = mk(s, K_ERROR, 8'h00, e);
		return o;
	endfunction

	function automatic err_t check(input st_t s);
		err_t e;
		e = E_NONE;
		if (s.pos == 3'd0) begin
			if (s.cnt > CNT_W'(ID_MAX_LEN))
				e = E_ID_LONG;
			else if (s.dbad)
				e = E_ID_NONNUM;
		end else if (s.pos == 3'd1) begin
			if (s.cnt > CNT_W'(IBAN_MAX_LEN))
				e = E_IBAN_LONG;
		end else if (s.pos == 3'(LAST_FIELD)) begin
			if (s.cnt > CNT_W'(REF_MAX_LEN))
				e = E_REF_LONG;
		end
		return e;
	endfunction

	function automatic step_t end_field(input st_t s, input logic row);
		step_t o;
		st_t   t;
		err_t  e;
		e     = check(s);
		o     = none(s);
		o.vld = 1'b1;
		o.res = mk(s, K_FIELD_END, 8'h00, E_NONE);
		t     = s;
		if (e != E_NONE) begin
			o = fail(s, e);
		end else if (!row) begin
			o.st.cnt  = '0;
			o.st.acc  = '0;
			o.st.dbad = 1'b0;
			if (s.pos < 3'(FIELD_SAT))
				o.st.pos = s.pos + 3'd1;
		end else if (s.pos != 3'(LAST_FIELD)) begin
			o = fail(s, E_VALUE_COUNT);
		end else begin
			if (t.rows != '1)
				t.rows = t.rows + ROW_W'(1);
			o.res  = mk(t, K_ROW_END, 8'h00, E_NONE);
			t.cnt  = '0;
			t.acc  = '0;
			t.dbad = 1'b0;
			t.pos  = '0;
			o.st   = t;
		end
		return o;
	endfunction

	function automatic step_t add_char(input st_t s, input logic [7:0] ch);
		step_t o;
		o = none(s);
		if (s.cnt >= CNT_W'(FIELD_BUFFER_LEN - 1)) begin
			o = fail(s, E_FIELD_LONG);
		end else begin
			if (s.pos == 3'd0) begin
				if ((ch >= CH_ZERO) && (ch <= CH_NINE)) begin
					if (s.cnt < CNT_W'(ID_MAX_LEN))
						o.st.acc = (s.acc << 3) + (s.acc << 1) + ACCOUNT_W'(ch - CH_ZERO);
				end else begin
					o.st.dbad = 1'b1;
				end
			end
			o.st.cnt = s.cnt + CNT_W'(1);
			o.vld    = 1'b1;
			o.res    = mk(o.st, K_CHAR, ch, E_NONE);
		end
		return o;
	endfunction

	function automatic step_t plain_byte(input st_t s, input logic [7:0] ch);
		step_t o;
		st_t   t;
		t = s;
		case (ch)
			CH_COMMA: begin
				t.mode = M_START;
				o = end_field(t, 1'b0);
			end
			CH_CR: begin
				t.mode = M_CRSEEN;
				o = end_field(t, 1'b1);
			end
			CH_LF: begin
				t.mode = M_START;
				o = end_field(t, 1'b1);
			end
			CH_QUOTE: begin
				o = fail(s, E_QUOTE_UNQ);
			end
			default: begin
				t.mode = M_PLAIN;
				o = add_char(t, ch);
			end
		endcase
		return o;
	endfunction

	function automatic step_t start_byte(input st_t s, input logic [7:0] ch);
		step_t o;
		if (ch == CH_QUOTE) begin
			o = none(s);
			o.st.mode = M_QUOTED;
		end else begin
			o = plain_byte(s, ch);
		end
		return o;
	endfunction

	function automatic step_t take_byte(input st_t s, input logic [7:0] ch);
		step_t o;
		st_t   t;
		t = s;
		case (s.mode)
			M_START:  o = start_byte(s, ch);
			M_PLAIN:  o = plain_byte(s, ch);
			M_QUOTED: begin
				if (ch == CH_QUOTE) begin
					o = none(s);
					o.st.mode = M_QSEEN;
				end else begin
					o = add_char(s, ch);
				end
			end
			M_QSEEN: begin
				case (ch)
					CH_QUOTE: begin
						t.mode = M_QUOTED;
						o = add_char(t, CH_QUOTE);
					end
					CH_COMMA: begin
						t.mode = M_START;
						o = end_field(t, 1'b0);
					end
					CH_CR: begin
						t.mode = M_CRSEEN;
						o = end_field(t, 1'b1);
					end
					CH_LF: begin
						t.mode = M_START;
						o = end_field(t, 1'b1);
					end
					default: o = fail(s, E_AFTER_QUOTE);
				endcase
			end
			M_CRSEEN: begin
				t.mode = M_START;
				// LF after CR completes a CRLF row end already counted
				if (ch == CH_LF)
					o = none(t);
				else
					o = start_byte(t, ch);
			end
			default: o = none(s);
		endcase
		return o;
	endfunction

	function automatic fin_t take_final(input st_t s);
		fin_t  f;
		step_t a;
		step_t b;
		st_t   t;
		t    = s;
		f.st = s;
		f.n  = 2'd0;
		f.r0 = mk(s, K_CHAR, 8'h00, E_NONE);
		f.r1 = f.r0;
		if (s.mode == M_QUOTED) begin
			a    = fail(s, E_NO_END_QUOTE);
			f.st = a.st;
			f.r0 = a.res;
			f.n  = 2'd1;
		end else if (s.mode != M_ENDED) begin
			// close an open row before the final count
			if ((s.mode == M_PLAIN) || (s.mode == M_QSEEN) ||
					((s.mode == M_START) && (s.pos != 3'd0))) begin
				t.mode = M_START;
				a      = end_field(t, 1'b1);
				t      = a.st;
				f.r0   = a.res;
				f.n    = 2'd1;
			end
			f.st = t;
			if (t.mode != M_ENDED) begin
				if (t.rows == '0) begin
					b = fail(t, E_NO_ROWS);
				end else begin
					b         = none(t);
					b.vld     = 1'b1;
					b.res     = mk(t, K_DONE, 8'h00, E_NONE);
					b.st.mode = M_ENDED;
				end
				f.st = b.st;
				if (f.n == 2'd0)
					f.r0 = b.res;
				else
					f.r1 = b.res;
				f.n = f.n + 2'd1;
			end
		end
		return f;
	endfunction

	always_comb begin
		if (item_s1.carries_byte)
			byte_step = take_byte(st_q, item_s1.data_byte);
		else
			byte_step = none(st_q);

		if (item_s1.final_req) begin
			fin_step = take_final(byte_step.st);
			nxt      = fin_step.st;
		end else begin
			fin_step.st = byte_step.st;
			fin_step.n  = 2'd0;
			fin_step.r0 = byte_step.res;
			fin_step.r1 = byte_step.res;
			nxt         = byte_step.st;
		end

		if (byte_step.vld) begin
			bundle.cnt  = fin_step.n + 2'd1;
			bundle.r[0] = byte_step.res;
			bundle.r[1] = fin_step.r0;
			bundle.r[2] = fin_step.r1;
		end else begin
			bundle.cnt  = fin_step.n;
			bundle.r[0] = fin_step.r0;
			bundle.r[1] = fin_step.r1;
			bundle.r[2] = fin_step.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode <= M_START;
			st_q.pos  <= '0;
			st_q.cnt  <= '0;
			st_q.acc  <= '0;
			st_q.dbad <= 1'b0;
			st_q.rows <= '0;
		end else if (advance) begin
			st_q <= nxt;
		end
	end

`ifndef SYNTHESIS
	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == M_ENDED |=> st_q.mode == M_ENDED)
		else $error("scanner left the ended mode");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pos <= 3'(FIELD_SAT))
		else $error("field position beyond saturation");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cnt <= CNT_W'(FIELD_BUFFER_LEN - 1))
		else $error("field character count beyond buffer limit");
`endif

endmodule

// File: rtl/csvrt_outq.sv
// ----------------------------------------------------------------------------
// csvrt_outq
// Result register: holds the up to three results of one transaction and
// hands them out one per cycle while token_stall is low, marking the last one.
// ----------------------------------------------------------------------------
module csvrt_outq import csvrt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  load_t ld,
	input  logic  token_stall,
	output logic  token_valid,
	output out_t  token,
	output logic  free
);

	out_t [2:0] slot_q;
	logic [1:0] cnt_q;
	logic [1:0] ptr_q;
	logic       pop;
	logic       last;

	assign token_valid = (cnt_q != 2'd0);
	assign last        = (ptr_q == cnt_q - 2'd1);
	assign pop         = token_valid && !token_stall;
	assign free        = !token_valid || (pop && last);

	always_comb begin
		token             = slot_q[ptr_q];
		token.last_of_run = last;
	end

	always_ff @(posedge clk) begin
		if (ld.load)
			slot_q <= ld.bundle.r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			ptr_q <= 2'd0;
		end else if (ld.load) begin
			cnt_q <= ld.bundle.cnt;
			ptr_q <= 2'd0;
		end else if (pop) begin
			if (last) begin
				cnt_q <= 2'd0;
				ptr_q <= 2'd0;
			end else begin
				ptr_q <= ptr_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> ptr_q < cnt_q)
		else $error("result pointer beyond loaded count");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld.load |-> free && ld.bundle.cnt != 2'd0)
		else $error("results loaded over pending results");
`endif

endmodule

// File: rtl/csv_record_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// Streaming CSV record tokenizer: at most one content byte per transaction, emits
// field characters, field ends, row ends, errors and a final done result.
// ----------------------------------------------------------------------------
// Path: an accepted transaction is held in the input register; its decoded
//   results are loaded into the result register and handed out from there.
// Throughput: one transaction per cycle while neither side stalls; a
//   transaction with several results holds the result register until all are handed out, one per cycle.
// Reset: arst_n clears the scanner state, row count and the valid flags of both registers.
module csv_record_tokenizer import csvrt_pkg::*; #(
	parameter int FIELD_BUFFER_LEN = FIELD_BUFFER_LEN_DEF,
	parameter int ROW_COUNT_BITS   = ROW_COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  in_t  item,
	output logic token_valid,
	input  logic token_stall,
	output out_t token
);

	logic  valid_s1;
	in_t   item_s1;
	bnd_t  bundle;
	logic  free;
	logic  proc;
	load_t ld;

	// Advance an item once its results fit in the result register.
	assign proc       = valid_s1 && ((bundle.cnt == 2'd0) || free);
	assign item_stall = valid_s1 && !proc;
	assign ld.load    = proc && (bundle.cnt != 2'd0);
	assign ld.bundle  = bundle;

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	csvrt_core #(
		.FIELD_BUFFER_LEN (FIELD_BUFFER_LEN),
		.ROW_COUNT_BITS   (ROW_COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (proc),
		.item_s1 (item_s1),
		.bundle  (bundle)
	);

	csvrt_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.ld          (ld),
		.token_stall (token_stall),
		.token_valid (token_valid),
		.token       (token),
		.free        (free)
	);

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams CSV content through csv_record_tokenizer at most one byte per transaction.
// A behavioral tracker predicts every token and checks each received token
// in order. Each run ends with one randomly chosen closing case (clean done,
// or one of the error cases), since the block stops for good after it.
// ----------------------------------------------------------------------------
module tb_top;
	import csvrt_pkg::*;

	localparam int BUF_LEN        = FIELD_BUFFER_LEN_DEF;
	localparam int ITEM_GOAL      = 400;
	localparam int SQUEEZE_AT     = 40;
	localparam int SQUEEZE_CYCLES = 200;
	localparam int DRAIN_CYCLES   = 50;
	localparam int LIMIT_NS       = 5_000_000;

	typedef enum int {
		END_AT_ROW,
		END_WITH_CHAR,
		END_TRAIL_COMMA,
		END_COMMA_FINAL,
		END_AFTER_QUOTE,
		BAD_QUOTE,
		BAD_AFTER_QUOTE,
		BAD_OPEN_QUOTE,
		BAD_LONG_FIELD,
		BAD_ID_LONG,
		BAD_ID_CHAR,
		BAD_IBAN,
		BAD_REF,
		BAD_EMPTY_LINE,
		BAD_COUNT,
		BAD_NO_ROWS
	} ending_t;

	class csv_token_tracker;
		mode_t                mode;
		logic [2:0]           fpos;
		int                   nchars;
		logic [ACCOUNT_W-1:0] acct;
		logic [ROWS_W-1:0]    rows;
		bit                   id_bad;
		out_t                 pending[$];
		int                   fails;

		function new();
			mode   = M_START;
			fpos   = '0;
			rows   = '0;
			fails  = 0;
			clear_field();
		endfunction

		function void clear_field();
			nchars = 0;
			acct   = '0;
			id_bad = 1'b0;
		endfunction

		function void push_token(kind_t k, logic [7:0] ch, err_t e);
			out_t t;
			t.kind          = k;
			t.field_char    = ch;
			t.field_number  = fpos;
			t.account_value = acct;
			t.rows_done     = rows;
			t.error_code    = e;
			t.last_of_run   = 1'b0;
			pending.push_back(t);
		endfunction

		function void abort(err_t e);
			push_token(K_ERROR, 8'h00, e);
			mode = M_ENDED;
		endfunction

		function void add_char(logic [7:0] ch);
			if (nchars >= BUF_LEN - 1) begin
				abort(E_FIELD_LONG);
				return;
			end
			if (fpos == 0) begin
				if (ch >= CH_ZERO && ch <= CH_NINE) begin
					if (nchars < ID_MAX_LEN)
						acct = acct * 10 + ACCOUNT_W'(ch - CH_ZERO);
				end else begin
					id_bad = 1'b1;
				end
			end
			nchars++;
			push_token(K_CHAR, ch, E_NONE);
		endfunction

		function err_t field_fault();
			if (fpos == 0) begin
				if (nchars > ID_MAX_LEN) return E_ID_LONG;
				if (id_bad) return E_ID_NONNUM;
			end else if (fpos == 1) begin
				if (nchars > IBAN_MAX_LEN) return E_IBAN_LONG;
			end else if (fpos == LAST_FIELD) begin
				if (nchars > REF_MAX_LEN) return E_REF_LONG;
			end
			return E_NONE;
		endfunction

		function void close_field(bit row_end);
			err_t e;
			e = field_fault();
			if (e != E_NONE) begin
				abort(e);
				return;
			end
			if (!row_end) begin
				push_token(K_FIELD_END, 8'h00, E_NONE);
				clear_field();
				if (fpos < FIELD_SAT) fpos++;
				return;
			end
			if (fpos != LAST_FIELD) begin
				abort(E_VALUE_COUNT);
				return;
			end
			if (rows != {ROWS_W{1'b1}}) rows++;
			push_token(K_ROW_END, 8'h00, E_NONE);
			clear_field();
			fpos = '0;
		endfunction

		function void unquoted_byte(logic [7:0] b);
			if (b == CH_COMMA) begin
				mode = M_START;
				close_field(1'b0);
			end else if (b == CH_CR) begin
				mode = M_CRSEEN;
				close_field(1'b1);
			end else if (b == CH_LF) begin
				mode = M_START;
				close_field(1'b1);
			end else if (b == CH_QUOTE) begin
				abort(E_QUOTE_UNQ);
			end else begin
				mode = M_PLAIN;
				add_char(b);
			end
		endfunction

		function void field_start_byte(logic [7:0] b);
			if (b == CH_QUOTE) mode = M_QUOTED;
			else unquoted_byte(b);
		endfunction

		function void take_byte(logic [7:0] b);
			case (mode)
				M_START: field_start_byte(b);
				M_PLAIN: unquoted_byte(b);
				M_QUOTED: begin
					if (b == CH_QUOTE) mode = M_QSEEN;
					else add_char(b);
				end
				M_QSEEN: begin
					if (b == CH_QUOTE) begin
						mode = M_QUOTED;
						add_char(CH_QUOTE);
					end else if (b == CH_COMMA || b == CH_CR || b == CH_LF) begin
						unquoted_byte(b);
					end else begin
						abort(E_AFTER_QUOTE);
					end
				end
				M_CRSEEN: begin
					// swallow the LF of a CRLF pair
					mode = M_START;
					if (b != CH_LF) field_start_byte(b);
				end
				default: ;
			endcase
		endfunction

		function void take_final();
			if (mode == M_ENDED) return;
			if (mode == M_QUOTED) begin
				abort(E_NO_END_QUOTE);
				return;
			end
			if (mode == M_PLAIN || mode == M_QSEEN || (mode == M_START && fpos != 0)) begin
				mode = M_START;
				close_field(1'b1);
				if (mode == M_ENDED) return;
			end
			if (rows == 0) begin
				abort(E_NO_ROWS);
			end else begin
				push_token(K_DONE, 8'h00, E_NONE);
				mode = M_ENDED;
			end
		endfunction

		function void take_item(in_t x);
			int   start_size;
			out_t t;
			if (mode == M_ENDED) return;
			start_size = pending.size();
			if (x.carries_byte) take_byte(x.data_byte);
			if (x.final_req) take_final();
			if (pending.size() > start_size) begin
				t = pending.pop_back();
				t.last_of_run = 1'b1;
				pending.push_back(t);
			end
		endfunction

		function void field_diff(string label, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
				fails++;
			end
		endfunction

		function void match_token(out_t got);
			out_t want;
			if (pending.size() == 0) begin
				$display("%0t: token expected none, got kind %0d char %0d error %0d",
					$time, got.kind, got.field_char, got.error_code);
				fails++;
				return;
			end
			want = pending.pop_front();
			field_diff("kind", want.kind, got.kind);
			field_diff("field_char", want.field_char, got.field_char);
			field_diff("field_number", want.field_number, got.field_number);
			field_diff("account_value", want.account_value, got.account_value);
			field_diff("rows_done", want.rows_done, got.rows_done);
			field_diff("error_code", want.error_code, got.error_code);
			field_diff("last_of_run", want.last_of_run, got.last_of_run);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_t  item;
	logic token_valid;
	logic token_stall;
	out_t token;

	csv_token_tracker tracker = new();
	int bytes_sent  = 0;
	int items_taken = 0;
	bit calm        = 1'b0;

	csv_record_tokenizer #(
		.FIELD_BUFFER_LEN(BUF_LEN),
		.ROW_COUNT_BITS  (ROWS_W)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token      (token)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int idle_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic in_t make_item(logic [7:0] b, logic carries, logic fin);
		in_t x;
		x.data_byte    = b;
		x.carries_byte = carries;
		x.final_req    = fin;
		return x;
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] b;
		do b = 8'($urandom);
		while (b == CH_COMMA || b == CH_CR || b == CH_LF || b == CH_QUOTE);
		return b;
	endfunction

	function automatic logic [7:0] digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic int field_len(int pos);
		bit top;
		top = ($urandom_range(0, 19) == 0);
		case (pos)
			0:       return top ? ID_MAX_LEN : $urandom_range(0, ID_MAX_LEN);
			1:       return top ? IBAN_MAX_LEN : $urandom_range(0, 12);
			2:       return top ? BUF_LEN - 1 : $urandom_range(0, 8);
			default: return top ? REF_MAX_LEN : $urandom_range(0, 16);
		endcase
	endfunction

	// Enter at a falling edge, leave at the falling edge after acceptance.
	task automatic send(in_t x);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			item <= make_item(8'($urandom), 1'($urandom), 1'($urandom));
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		do @(posedge clk);
		while (item_stall);
		tracker.take_item(x);
		items_taken++;
		@(negedge clk);
	endtask

	task automatic put_byte(logic [7:0] b);
		if ($urandom_range(0, 29) == 0)
			send(make_item(8'($urandom), 1'b0, 1'b0));
		send(make_item(b, 1'b1, 1'b0));
		bytes_sent++;
	endtask

	task automatic put_final(logic carries, logic [7:0] b);
		send(make_item(b, carries, 1'b1));
	endtask

	task automatic put_text(string s);
		int i;
		for (i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	task automatic put_field(int pos, int len);
		bit         quoted;
		logic [7:0] b;
		int         i;
		int         r;
		quoted = ($urandom_range(0, 3) == 0);
		if (quoted) put_byte(CH_QUOTE);
		for (i = 0; i < len; i++) begin
			r = $urandom_range(0, 9);
			if (pos == 0) b = digit();
			else if (!quoted) b = plain_char();
			else if (r == 0) b = CH_QUOTE;
			else if (r == 1) b = ($urandom_range(0, 1) == 0) ? CH_COMMA : CH_CR;
			else if (r == 2) b = CH_LF;
			else b = 8'($urandom);
			put_byte(b);
			// double the quote inside a quoted field
			if (quoted && b == CH_QUOTE) put_byte(CH_QUOTE);
		end
		if (quoted) put_byte(CH_QUOTE);
	endtask

	task automatic put_lead(int n);
		int pos;
		for (pos = 0; pos < n; pos++) begin
			put_field(pos, field_len(pos));
			put_byte(CH_COMMA);
		end
	endtask

	task automatic put_row_end();
		case ($urandom_range(0, 2))
			0: begin
				put_byte(CH_CR);
				put_byte(CH_LF);
			end
			1: put_byte(CH_CR);
			default: put_byte(CH_LF);
		endcase
	endtask

	task automatic put_row();
		calm = ($urandom_range(0, 4) == 0);
		put_lead(LAST_FIELD);
		put_field(LAST_FIELD, field_len(LAST_FIELD));
		put_row_end();
	endtask

	// Receiver: random hold-offs, plus one long squeeze to back up the input.
	initial begin
		int hold_left;
		bit squeezed;
		token_stall = 1'b0;
		hold_left   = 0;
		squeezed    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!squeezed && items_taken >= SQUEEZE_AT) begin
				squeezed  = 1'b1;
				hold_left = SQUEEZE_CYCLES;
			end
			if (hold_left > 0) begin
				token_stall <= 1'b1;
				hold_left--;
			end else begin
				token_stall <= 1'b0;
				hold_left = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) tracker.match_token(token);
	end

	initial begin
		ending_t ending;
		item_valid = 1'b0;
		item       = make_item(8'h00, 1'b0, 1'b0);
		arst_n     = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		ending = ending_t'($urandom_range(0, 15));
		if (ending == BAD_NO_ROWS) begin
			// no row may complete before the closing transaction
			repeat ($urandom_range(1, 20)) send(make_item(8'($urandom), 1'b0, 1'b0));
			put_final(1'b0, 8'($urandom));
		end else begin
			put_text("999999999,\"A\"\"B\",");
			put_byte(8'hFF);
			put_text(",\"x,y\"\r\n");
			send(make_item(8'h00, 1'b0, 1'b0));
			put_text("0,,,\r");

			while (bytes_sent < ITEM_GOAL) put_row();
			calm = 1'b0;

			case (ending)
				END_AT_ROW: put_final(1'b0, 8'($urandom));
				END_WITH_CHAR: begin
					put_lead(LAST_FIELD);
					put_final(1'b1, plain_char());
				end
				END_TRAIL_COMMA: begin
					put_lead(LAST_FIELD);
					put_final(1'b0, 8'($urandom));
				end
				END_COMMA_FINAL: begin
					put_lead(2);
					put_field(2, field_len(2));
					put_final(1'b1, CH_COMMA);
				end
				END_AFTER_QUOTE: begin
					put_lead(LAST_FIELD);
					put_text("\"r\"");
					put_final(1'b0, 8'($urandom));
				end
				BAD_QUOTE: begin
					put_lead(1);
					put_text("ab\"");
				end
				BAD_AFTER_QUOTE: begin
					put_lead(1);
					put_text("\"ab\"c");
				end
				BAD_OPEN_QUOTE: begin
					put_lead(1);
					put_text("\"ab");
					put_final(1'b0, 8'($urandom));
				end
				BAD_LONG_FIELD: begin
					put_lead(2);
					repeat (BUF_LEN) put_byte(plain_char());
				end
				BAD_ID_LONG: begin
					repeat (ID_MAX_LEN + 1) put_byte(digit());
					put_byte(CH_COMMA);
				end
				BAD_ID_CHAR: put_text("12x,");
				BAD_IBAN: begin
					put_lead(1);
					repeat (IBAN_MAX_LEN + 1) put_byte(plain_char());
					put_byte(CH_COMMA);
				end
				BAD_REF: begin
					put_lead(LAST_FIELD);
					repeat (REF_MAX_LEN + 1) put_byte(plain_char());
					put_byte(CH_CR);
				end
				BAD_EMPTY_LINE: begin
					// the first LF may close a pending CR, the second is the empty line
					put_byte(CH_LF);
					put_byte(CH_LF);
				end
				default: begin
					put_lead(($urandom_range(0, 1) == 0) ? 2 : 5);
					put_row_end();
				end
			endcase
		end

		// The run has ended; these must produce nothing.
		repeat (3) send(make_item(8'($urandom), 1'($urandom), 1'($urandom)));
		item_valid <= 1'b0;

		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
